[sv/hrlog_pkg.sv]
// ----------------------------------------------------------------------------
// hrlog_pkg
// Types, constants and helpers shared by the heart-rate logger modules.
// ----------------------------------------------------------------------------
package hrlog_pkg;

    localparam int SLOT_MINUTES     = 10;
    localparam int SLOTS_PER_DAY    = 144;
    localparam int HOURS_PER_DAY    = 24;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int DEFAULT_DURATION = 45;

    localparam int RATE_W    = 8;
    localparam int SLOT_W    = 8;
    localparam int HOUR_W    = $clog2(HOURS_PER_DAY + 1);
    localparam int CLK_HR_W  = 5;
    localparam int CLK_MIN_W = 6;
    localparam int TOTAL_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [HOUR_W-1:0] NO_HOUR = HOUR_W'(HOURS_PER_DAY);

    // minute-of-day / SLOT_MINUTES by exact reciprocal
    localparam int DIV_SHIFT  = TOTAL_W + $clog2(SLOT_MINUTES);
    localparam int DIV_MUL    = ((1 << DIV_SHIFT) + SLOT_MINUTES - 1) / SLOT_MINUTES;
    localparam int DIV_PROD_W = 2 * TOTAL_W + 1;
    localparam int REM_W      = TOTAL_W + $clog2(SLOT_MINUTES + 1);

    // slot / slots-per-hour by exact reciprocal
    localparam int SLOTS_PER_HOUR = MINUTES_PER_HOUR / SLOT_MINUTES;
    localparam int HR_SHIFT       = SLOT_W + $clog2(SLOTS_PER_HOUR);
    localparam int HR_MUL         = ((1 << HR_SHIFT) + SLOTS_PER_HOUR - 1) / SLOTS_PER_HOUR;
    localparam int HR_PROD_W      = 2 * SLOT_W + 1;
    localparam int SPD_W          = $clog2(SLOTS_PER_DAY + 1);
    localparam int SLOT_CMP_W     = (SPD_W > SLOT_W) ? SPD_W : SLOT_W;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_SECOND = 2'd1,
        CMD_MINUTE = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTO_DURATION = 1'b0,
        CFG_AUTO_ON       = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]           command;
        logic [RATE_W-1:0]    hr_value;
        logic [CLK_HR_W-1:0]  clock_hour;
        logic [CLK_MIN_W-1:0] clock_minute;
        logic                 bonded;
        logic                 sensor_enabled;
        logic                 sensor_on_hr;
        logic                 manual_mode;
        logic                 asleep;
        logic                 charging;
        logic                 upgrading;
    } t_in;

    typedef struct packed {
        logic [RATE_W-1:0] latest_rate;
        logic [RATE_W-1:0] hour_low;
        logic [RATE_W-1:0] hour_high;
        logic [SLOT_W-1:0] current_slot;
        logic              start_sensor;
        logic              stop_sensor;
        logic              day_rollover;
    } t_out;

    typedef struct packed {
        t_in                item;
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] quot;
    } t_stage;

    function automatic logic [HOUR_W-1:0] slot_hour(input logic [SLOT_W-1:0] slot);
        logic [HR_PROD_W-1:0] prod;
        logic [SLOT_W-1:0]    hour;
        logic [HOUR_W-1:0]    res;
        prod = HR_PROD_W'(slot) * HR_PROD_W'(HR_MUL);
        hour = SLOT_W'(prod >> HR_SHIFT);
        if (SLOT_CMP_W'(slot) >= SLOT_CMP_W'(SLOTS_PER_DAY)
            || hour >= SLOT_W'(HOURS_PER_DAY)) begin
            res = NO_HOUR;
        end else begin
            res = HOUR_W'(hour);
        end
        return res;
    endfunction

endpackage

[sv/hrlog_obuf.sv]
// ----------------------------------------------------------------------------
// hrlog_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module hrlog_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hrlog_pkg::t_out   i_push_data,
    output logic              o_full,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hrlog_pkg::t_out   o_out_data
);

    logic            r_out_valid;
    logic            r_skid_valid;
    hrlog_pkg::t_out r_out;
    hrlog_pkg::t_out r_skid;
    logic            w_take;

    assign w_take      = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= i_push_data;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out <= i_push_data;
            end else begin
                r_skid <= i_push_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed into a full buffer");

    a_skid_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && r_skid_valid |=> r_out_valid && !r_skid_valid)
        else $error("skid entry lost on transfer");
`endif

endmodule

[sv/heart_rate_log_and_auto_measure.sv]
// ----------------------------------------------------------------------------
// heart_rate_log_and_auto_measure
// Heart-rate logger with hourly min/max tracking and auto measurement timing.
// ----------------------------------------------------------------------------
// One item is taken per clock. A transfer lands in an input register that
// also holds the minute-of-day quotient from a constant reciprocal multiply;
// once the output buffer has room, the item is applied to the logger state
// and its result is written into a two-entry output buffer. The input stalls
// only while both output entries are full and an item waits in the input
// register. Per-slot sample values are not retained, since no result field
// depends on them. Configuration writes are always ready and take effect on
// the next item.
module heart_rate_log_and_auto_measure (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  hrlog_pkg::t_in                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output hrlog_pkg::t_out                     o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hrlog_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hrlog_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int RW = hrlog_pkg::RATE_W;
    localparam int HD = hrlog_pkg::HOURS_PER_DAY;

    // configuration
    logic [RW-1:0] r_dur;
    logic          r_auto_on;

    // input stage
    logic                              r_s1_valid;
    hrlog_pkg::t_stage                 r_s1;
    logic [hrlog_pkg::TOTAL_W-1:0]     w_total;
    logic [hrlog_pkg::DIV_PROD_W-1:0]  w_prod;
    logic                              w_s1_load;
    logic                              w_s1_fire;
    logic                              w_full;

    // logger state
    logic [RW-1:0]                  r_last, n_last;
    logic [RW-1:0]                  r_min [HD];
    logic [RW-1:0]                  n_min [HD];
    logic [RW-1:0]                  r_max [HD];
    logic [RW-1:0]                  n_max [HD];
    logic [hrlog_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic                           r_armed, n_armed;
    logic [RW-1:0]                  r_run, n_run;

    logic [hrlog_pkg::HOUR_W-1:0]   w_h_cur;
    logic [hrlog_pkg::HOUR_W-1:0]   w_h_new;
    logic [RW-1:0]                  w_run_inc;
    logic                           w_slot_edge;
    logic                           w_start;
    logic                           w_stop;
    logic                           w_roll;
    hrlog_pkg::t_out                w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur     <= RW'(hrlog_pkg::DEFAULT_DURATION);
            r_auto_on <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (hrlog_pkg::t_cfg_idx'(i_cfg_index))
                hrlog_pkg::CFG_AUTO_DURATION: begin
                    r_dur <= i_cfg_data;
                end
                hrlog_pkg::CFG_AUTO_ON: begin
                    r_auto_on <= i_cfg_data[0];
                end
            endcase
        end
    end

    assign o_in_stall = r_s1_valid && w_full;
    assign w_s1_load  = i_in_valid && !o_in_stall;
    assign w_s1_fire  = r_s1_valid && !w_full;

    assign w_total = hrlog_pkg::TOTAL_W'(i_in_data.clock_hour)
                     * hrlog_pkg::TOTAL_W'(hrlog_pkg::MINUTES_PER_HOUR)
                     + hrlog_pkg::TOTAL_W'(i_in_data.clock_minute);
    assign w_prod  = hrlog_pkg::DIV_PROD_W'(w_total)
                     * hrlog_pkg::DIV_PROD_W'(hrlog_pkg::DIV_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1.item  <= i_in_data;
            r_s1.total <= w_total;
            r_s1.quot  <= hrlog_pkg::TOTAL_W'(w_prod >> hrlog_pkg::DIV_SHIFT);
        end
    end

    assign w_h_cur     = hrlog_pkg::slot_hour(r_slot);
    assign w_slot_edge = (hrlog_pkg::REM_W'(r_s1.quot)
                          * hrlog_pkg::REM_W'(hrlog_pkg::SLOT_MINUTES))
                         == hrlog_pkg::REM_W'(r_s1.total);

    always_comb begin
        n_last    = r_last;
        n_min     = r_min;
        n_max     = r_max;
        n_slot    = r_slot;
        n_armed   = r_armed;
        n_run     = r_run;
        w_run_inc = '0;
        w_start   = 1'b0;
        w_stop    = 1'b0;
        w_roll    = 1'b0;
        if (w_s1_fire) begin
            unique case (r_s1.item.command)
                hrlog_pkg::CMD_SAMPLE: begin
                    if (r_s1.item.hr_value != '0) begin
                        n_last = r_s1.item.hr_value;
                        if (w_h_cur != hrlog_pkg::NO_HOUR) begin
                            if (r_min[w_h_cur] == '0 || r_s1.item.hr_value < r_min[w_h_cur]) begin
                                n_min[w_h_cur] = r_s1.item.hr_value;
                            end
                            if (r_max[w_h_cur] == '0 || r_s1.item.hr_value > r_max[w_h_cur]) begin
                                n_max[w_h_cur] = r_s1.item.hr_value;
                            end
                        end
                    end
                end
                hrlog_pkg::CMD_SECOND: begin
                    if (r_s1.item.bonded && !(r_armed && r_s1.item.sensor_enabled)) begin
                        if (r_armed) begin
                            n_armed = 1'b0;
                            w_start = 1'b1;
                        end
                        if (!r_s1.item.sensor_on_hr || r_s1.item.manual_mode
                            || r_s1.item.asleep) begin
                            n_run = '0;
                        end else begin
                            w_run_inc = (r_armed ? '0 : r_run) + RW'(1);
                            if (w_run_inc >= r_dur) begin
                                n_run  = '0;
                                w_stop = 1'b1;
                            end else begin
                                n_run = w_run_inc;
                            end
                        end
                    end
                end
                hrlog_pkg::CMD_MINUTE: begin
                    if (r_s1.item.bonded) begin
                        if (r_s1.item.clock_hour == '0 && r_s1.item.clock_minute == '0) begin
                            w_roll = 1'b1;
                            n_last = '0;
                            n_min  = '{default: '0};
                            n_max  = '{default: '0};
                        end
                        n_slot  = r_s1.quot[hrlog_pkg::SLOT_W-1:0];
                        n_armed = w_slot_edge && r_auto_on && !r_s1.item.charging
                                  && !r_s1.item.upgrading && !r_s1.item.sensor_on_hr
                                  && !r_s1.item.asleep;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_h_new = hrlog_pkg::slot_hour(n_slot);

    always_comb begin
        w_res.latest_rate  = n_last;
        w_res.hour_low     = (w_h_new == hrlog_pkg::NO_HOUR) ? '0 : n_min[w_h_new];
        w_res.hour_high    = (w_h_new == hrlog_pkg::NO_HOUR) ? '0 : n_max[w_h_new];
        w_res.current_slot = n_slot;
        w_res.start_sensor = w_start;
        w_res.stop_sensor  = w_stop;
        w_res.day_rollover = w_roll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_min   <= '{default: '0};
            r_max   <= '{default: '0};
            r_slot  <= '0;
            r_armed <= 1'b0;
            r_run   <= '0;
        end else begin
            r_last  <= n_last;
            r_min   <= n_min;
            r_max   <= n_max;
            r_slot  <= n_slot;
            r_armed <= n_armed;
            r_run   <= n_run;
        end
    end

    hrlog_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_s1_fire),
        .i_push_data (w_res),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with an empty input register");

    a_rollover_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire && w_res.day_rollover |->
            w_res.latest_rate == '0 && w_res.hour_low == '0 && w_res.hour_high == '0)
        else $error("day rollover left logged rates");

    a_start_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire && w_res.start_sensor |=> !r_armed)
        else $error("auto measurement still armed after start");

    a_slot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_s1_fire && r_s1.item.command == hrlog_pkg::CMD_MINUTE && r_s1.item.bonded)
            |=> $stable(r_slot))
        else $error("slot index moved without a minute tick");
`endif

endmodule

[sim/heart_rate_log_and_auto_measure_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heart_rate_log_and_auto_measure_tb
// Self-checking bench for the heart-rate logger and auto measurement timer.
// Directed samples and clock ticks cover the edges of the slot and clock
// ranges, then long runs of measurement sessions mixed with random noise are
// sent under several duration and enable settings. Every transfer is run
// through a local model of the logger, and each result is checked field by
// field against the oldest expected one while both sides throttle at random.
// ----------------------------------------------------------------------------
module heart_rate_log_and_auto_measure_tb;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int REPORT_MAX   = 10;
    localparam int HOLD_CYCLES  = 90;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            o_in_stall;
    hrlog_pkg::t_in                  in_data = '0;
    logic                            o_out_valid;
    logic                            out_stall = 1'b0;
    hrlog_pkg::t_out                 o_out_data;
    logic                            cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [hrlog_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hrlog_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    heart_rate_log_and_auto_measure i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // logger model state and configuration copy
    logic [hrlog_pkg::RATE_W-1:0] rate_last = '0;
    logic [hrlog_pkg::RATE_W-1:0] hour_min_log [hrlog_pkg::HOURS_PER_DAY];
    logic [hrlog_pkg::RATE_W-1:0] hour_max_log [hrlog_pkg::HOURS_PER_DAY];
    logic [hrlog_pkg::SLOT_W-1:0] slot_ptr = '0;
    logic                         auto_armed_q = 1'b0;
    logic [7:0]                   run_secs = '0;
    logic [7:0]                   cfg_duration = 8'(hrlog_pkg::DEFAULT_DURATION);
    logic                         cfg_auto_on = 1'b1;

    hrlog_pkg::t_in  pending_items [$];
    hrlog_pkg::t_out expected_logs [$];

    int   queued_items = 0;
    int   fail_count = 0;
    int   mismatch_count = 0;
    int   checked_count = 0;
    int   start_count = 0;
    int   stop_count = 0;
    int   rollover_count = 0;
    int   sample_count = 0;
    int   second_count = 0;
    int   minute_count = 0;
    int   setting_count = 0;
    logic in_taken = 1'b0;
    int   send_burst = 0;
    int   send_gap = 0;
    int   rx_cycle = 0;
    int   hold_left = 0;
    int   next_hold = 0;

    initial begin
        for (int k = 0; k < hrlog_pkg::HOURS_PER_DAY; k++) begin
            hour_min_log[k] = '0;
            hour_max_log[k] = '0;
        end
    end

    function automatic hrlog_pkg::t_out predict_log_output(input hrlog_pkg::t_in it);
        hrlog_pkg::t_out res;
        int   total;
        int   hidx;
        bit   go_on;
        res = '0;
        case (it.command)
            hrlog_pkg::CMD_SAMPLE: begin
                if (it.hr_value != 0) begin
                    rate_last = it.hr_value;
                    if (slot_ptr < hrlog_pkg::SLOTS_PER_DAY) begin
                        hidx = slot_ptr / hrlog_pkg::SLOTS_PER_HOUR;
                        if (hour_min_log[hidx] == 0 || it.hr_value < hour_min_log[hidx])
                            hour_min_log[hidx] = it.hr_value;
                        if (hour_max_log[hidx] == 0 || it.hr_value > hour_max_log[hidx])
                            hour_max_log[hidx] = it.hr_value;
                    end
                end
            end
            hrlog_pkg::CMD_SECOND: begin
                if (it.bonded) begin
                    go_on = 1'b1;
                    if (auto_armed_q) begin
                        if (it.sensor_enabled) begin
                            go_on = 1'b0;
                        end else begin
                            auto_armed_q = 1'b0;
                            run_secs = '0;
                            res.start_sensor = 1'b1;
                        end
                    end
                    if (go_on) begin
                        if (!it.sensor_on_hr || it.manual_mode || it.asleep) begin
                            run_secs = '0;
                        end else begin
                            run_secs = run_secs + 8'd1;
                            if (run_secs >= cfg_duration) begin
                                run_secs = '0;
                                res.stop_sensor = 1'b1;
                            end
                        end
                    end
                end
            end
            hrlog_pkg::CMD_MINUTE: begin
                if (it.bonded) begin
                    total = int'(it.clock_hour) * hrlog_pkg::MINUTES_PER_HOUR
                            + int'(it.clock_minute);
                    if (it.clock_hour == 0 && it.clock_minute == 0) begin
                        res.day_rollover = 1'b1;
                        rate_last = '0;
                        for (int k = 0; k < hrlog_pkg::HOURS_PER_DAY; k++) begin
                            hour_min_log[k] = '0;
                            hour_max_log[k] = '0;
                        end
                    end
                    slot_ptr = hrlog_pkg::SLOT_W'(total / hrlog_pkg::SLOT_MINUTES);
                    auto_armed_q = (total % hrlog_pkg::SLOT_MINUTES == 0) && cfg_auto_on
                        && !it.charging && !it.upgrading && !it.sensor_on_hr && !it.asleep;
                end
            end
            default: begin
            end
        endcase
        res.latest_rate = rate_last;
        res.current_slot = slot_ptr;
        if (slot_ptr < hrlog_pkg::SLOTS_PER_DAY) begin
            res.hour_low = hour_min_log[slot_ptr / hrlog_pkg::SLOTS_PER_HOUR];
            res.hour_high = hour_max_log[slot_ptr / hrlog_pkg::SLOTS_PER_HOUR];
        end
        return res;
    endfunction

    // transfers in both directions, sampled at the rising edge
    always @(posedge i_clk) begin
        hrlog_pkg::t_out want;
        logic bad;
        in_taken <= i_rst_n && in_valid && !o_in_stall;
        if (i_rst_n && in_valid && !o_in_stall) begin
            expected_logs.push_back(predict_log_output(in_data));
            case (in_data.command)
                hrlog_pkg::CMD_SAMPLE: sample_count++;
                hrlog_pkg::CMD_SECOND: second_count++;
                hrlog_pkg::CMD_MINUTE: minute_count++;
                default: ;
            endcase
        end
        if (i_rst_n && o_out_valid && !out_stall) begin
            checked_count++;
            if (expected_logs.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("result %0d arrived with nothing expected", checked_count);
            end else begin
                want = expected_logs.pop_front();
                start_count += want.start_sensor;
                stop_count += want.stop_sensor;
                rollover_count += want.day_rollover;
                bad = (o_out_data.latest_rate !== want.latest_rate)
                    || (o_out_data.hour_low !== want.hour_low)
                    || (o_out_data.hour_high !== want.hour_high)
                    || (o_out_data.current_slot !== want.current_slot)
                    || (o_out_data.start_sensor !== want.start_sensor)
                    || (o_out_data.stop_sensor !== want.stop_sensor)
                    || (o_out_data.day_rollover !== want.day_rollover);
                if (bad) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"result %0d mismatch: rate/low/high/slot/start/stop/roll",
                                  " expected %0d %0d %0d %0d %0b %0b %0b",
                                  " got %0d %0d %0d %0d %0b %0b %0b"},
                                 checked_count, want.latest_rate, want.hour_low,
                                 want.hour_high, want.current_slot, want.start_sensor,
                                 want.stop_sensor, want.day_rollover,
                                 o_out_data.latest_rate, o_out_data.hour_low,
                                 o_out_data.hour_high, o_out_data.current_slot,
                                 o_out_data.start_sensor, o_out_data.stop_sensor,
                                 o_out_data.day_rollover);
                end
            end
        end
    end

    // sender: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap--;
            end else if (pending_items.size() != 0) begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (send_burst <= 1) begin
                    send_burst = $urandom_range(1, 24);
                    send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    send_burst--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall patterns plus a long hold while items are queued
    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_left == 0 && rx_cycle >= next_hold && pending_items.size() > 100) begin
            hold_left = HOLD_CYCLES;
            next_hold = rx_cycle + 1500;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            case ((rx_cycle / 400) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((rx_cycle % 9) < 4);
            endcase
        end
    end

    function automatic hrlog_pkg::t_in mk_item(input logic [1:0] cmd, input int hr,
                                               input int hour, input int minute,
                                               input bit bonded, input bit sens_en,
                                               input bit on_hr, input bit manual,
                                               input bit asleep, input bit charging,
                                               input bit upgrading);
        hrlog_pkg::t_in it;
        it.command = cmd;
        it.hr_value = hrlog_pkg::RATE_W'(hr);
        it.clock_hour = hrlog_pkg::CLK_HR_W'(hour);
        it.clock_minute = hrlog_pkg::CLK_MIN_W'(minute);
        it.bonded = bonded;
        it.sensor_enabled = sens_en;
        it.sensor_on_hr = on_hr;
        it.manual_mode = manual;
        it.asleep = asleep;
        it.charging = charging;
        it.upgrading = upgrading;
        return it;
    endfunction

    function automatic hrlog_pkg::t_in rand_item();
        hrlog_pkg::t_in it;
        int  pick;
        it = $bits(hrlog_pkg::t_in)'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40)      it.command = hrlog_pkg::CMD_SAMPLE;
        else if (pick < 75) it.command = hrlog_pkg::CMD_SECOND;
        else if (pick < 95) it.command = hrlog_pkg::CMD_MINUTE;
        else                it.command = CMD_UNUSED;
        if ($urandom_range(0, 9) != 0) it.bonded = 1'b1;
        if (it.command == hrlog_pkg::CMD_SAMPLE && $urandom_range(0, 4) != 0)
            it.hr_value = hrlog_pkg::RATE_W'($urandom_range(30, 220));
        if (it.command == hrlog_pkg::CMD_MINUTE && $urandom_range(0, 9) != 0) begin
            it.clock_hour = hrlog_pkg::CLK_HR_W'($urandom_range(0, 23));
            it.clock_minute = hrlog_pkg::CLK_MIN_W'($urandom_range(0, 59));
            if ($urandom_range(0, 1) == 1)
                it.clock_minute = hrlog_pkg::CLK_MIN_W'(hrlog_pkg::SLOT_MINUTES
                                                        * $urandom_range(0, 5));
            if ($urandom_range(0, 19) == 0) begin
                it.clock_hour = '0;
                it.clock_minute = '0;
            end
            if ($urandom_range(0, 1) == 1) begin
                it.sensor_on_hr = 1'b0;
                it.asleep = 1'b0;
                it.charging = 1'b0;
                it.upgrading = 1'b0;
            end
        end
        if (it.command == hrlog_pkg::CMD_SECOND && $urandom_range(0, 1) == 1) begin
            it.sensor_on_hr = 1'b1;
            it.manual_mode = 1'b0;
            it.asleep = 1'b0;
        end
        return it;
    endfunction

    task automatic push_item(input hrlog_pkg::t_in it);
        pending_items.push_back(it);
        queued_items++;
    endtask

    // arm on a slot boundary, start, then count seconds with samples mixed in
    task automatic queue_session(input int seconds, input bit clean);
        bit upset;
        push_item(mk_item(hrlog_pkg::CMD_MINUTE, 0, $urandom_range(0, 23),
                          hrlog_pkg::SLOT_MINUTES * $urandom_range(0, 5), 1,
                          1'($urandom_range(0, 1)), 0, 1'($urandom_range(0, 1)),
                          0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SECOND, 0, $urandom_range(0, 31),
                          $urandom_range(0, 63), 1, 0, 1'($urandom_range(0, 1)), 0, 0,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        for (int k = 0; k < seconds; k++) begin
            if ($urandom_range(0, 2) == 0)
                push_item(mk_item(hrlog_pkg::CMD_SAMPLE, $urandom_range(35, 210), 0, 0,
                                  1'($urandom_range(0, 1)), 1, 1, 0, 0, 0, 0));
            upset = !clean && ($urandom_range(0, 29) == 0);
            push_item(mk_item(hrlog_pkg::CMD_SECOND, 0, 0, 0, 1, 1, 1, upset, 0, 0, 0));
        end
    endtask

    task automatic queue_random(input int count);
        int stop_at;
        stop_at = queued_items + count;
        while (queued_items < stop_at) begin
            if ($urandom_range(0, 9) < 4)
                queue_session($urandom_range(1, 40), 1'($urandom_range(0, 1)));
            else
                push_item(rand_item());
        end
    endtask

    task automatic queue_directed();
        push_item(mk_item(hrlog_pkg::CMD_SAMPLE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SAMPLE, 255, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SAMPLE, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SAMPLE, 100, 31, 63, 0, 1, 1, 1, 1, 1, 1));
        push_item(mk_item(hrlog_pkg::CMD_MINUTE, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SECOND, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_MINUTE, 0, 23, 59, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SAMPLE, 80, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_MINUTE, 0, 23, 50, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SECOND, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SECOND, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SECOND, 0, 0, 0, 1, 1, 1, 1, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_MINUTE, 0, 24, 0, 1, 0, 0, 0, 0, 1, 0));
        push_item(mk_item(hrlog_pkg::CMD_SAMPLE, 70, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_MINUTE, 0, 31, 63, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SAMPLE, 60, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(CMD_UNUSED, 200, 0, 0, 1, 1, 1, 1, 1, 1, 1));
        push_item(mk_item(hrlog_pkg::CMD_MINUTE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1));
        push_item(mk_item(hrlog_pkg::CMD_SAMPLE, 90, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_MINUTE, 0, 12, 30, 1, 0, 0, 0, 1, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_MINUTE, 0, 12, 40, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SECOND, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SECOND, 0, 0, 0, 1, 1, 1, 0, 1, 0, 0));
        push_item(mk_item(hrlog_pkg::CMD_SAMPLE, 150, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic write_cfg(input hrlog_pkg::t_cfg_idx idx, input int value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= hrlog_pkg::CFG_DAT_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == hrlog_pkg::CFG_AUTO_DURATION) cfg_duration = value[7:0];
        else cfg_auto_on = value[0];
        setting_count++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued transfer has its result back
    task automatic settle();
        while (checked_count < queued_items)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(hrlog_pkg::CFG_AUTO_DURATION, hrlog_pkg::DEFAULT_DURATION);
        write_cfg(hrlog_pkg::CFG_AUTO_ON, 1);
        queue_directed();
        settle();
        write_cfg(hrlog_pkg::CFG_AUTO_DURATION, 1);
        queue_random(300);
        settle();
        write_cfg(hrlog_pkg::CFG_AUTO_DURATION, 255);
        queue_session(262, 1);
        queue_random(100);
        settle();
        write_cfg(hrlog_pkg::CFG_AUTO_DURATION, 0);
        write_cfg(hrlog_pkg::CFG_AUTO_ON, 0);
        queue_random(200);
        settle();
        write_cfg(hrlog_pkg::CFG_AUTO_ON, 1);
        queue_random(150);
        settle();
        write_cfg(hrlog_pkg::CFG_AUTO_DURATION, $urandom_range(2, 30));
        queue_random(500);
        settle();
        write_cfg(hrlog_pkg::CFG_AUTO_DURATION, 3);
        queue_random(200);
        settle();
        $display("covered %0d samples, %0d second ticks, %0d minute ticks over %0d register writes",
                 sample_count, second_count, minute_count, setting_count);
        $display("checked %0d results: %0d starts, %0d stops, %0d rollovers, %0d failures",
                 checked_count, start_count, stop_count, rollover_count, fail_count);
        if (fail_count == 0) begin
            $display("heart_rate_log_and_auto_measure test passed");
        end else begin
            $display("heart_rate_log_and_auto_measure test failed");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("timeout with %0d results still expected", expected_logs.size());
        $display("heart_rate_log_and_auto_measure test failed");
        $finish;
    end

endmodule
